FILE: rtl/temp_average_overtemp_fault_assert.svh
// ----------------------------------------------------------------------------
// temp_average_overtemp_fault_assert
// Assertion macros shared by the temperature monitor rtl
// ----------------------------------------------------------------------------
`ifndef TEMP_AVERAGE_OVERTEMP_FAULT_ASSERT_SVH
`define TEMP_AVERAGE_OVERTEMP_FAULT_ASSERT_SVH

// condition holds at every edge outside reset
`define TAOF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("taof assertion failed");

// antecedent at one edge implies consequent at the next edge
`define TAOF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("taof assertion failed");

`endif

FILE: rtl/taof_pkg.sv
// ----------------------------------------------------------------------------
// taof_pkg
// Shared types and constants for the temperature average / fault monitor
// ----------------------------------------------------------------------------
package taof_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 2 * SAMPLE_W;
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [SAMPLE_W-1:0] FAILED_SAMPLE = 16'hFFFF;

  // register reset values
  localparam logic                RST_SENSOR_MODE = 1'b1;
  localparam logic [SAMPLE_W-1:0] RST_FILTER_BW   = 16'd16;
  localparam logic [SAMPLE_W-1:0] RST_TRIP        = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] RST_RELEASE     = 16'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_MODE = 2'd0,
    REG_FILTER_BW   = 2'd1,
    REG_TRIP        = 2'd2,
    REG_RELEASE     = 2'd3
  } reg_index_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip;
    logic div_last;
  } status_t;

endpackage

FILE: rtl/temp_average_overtemp_fault.sv
// ----------------------------------------------------------------------------
// temp_average_overtemp_fault
// Temperature sample averaging filter with hysteresis over-temperature fault
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one raw 16-bit converter sample per beat; m_* channel
//   returns one beat per sample with the fault flag and the running average. Registers are
//   written through cfg_we / cfg_index / cfg_data by the user, only while idle; it is unchecked.
// Timing:
//   A filtered sample goes from accept to result through one multiply,
//   one add and 16 steps of the one-bit-per-cycle restoring divider by the
//   bandwidth. A failed conversion or virtual mode skips the filter. One
//   sample is in flight at a time; s_tready is high only when the sequencer is idle.
// Reset:
//   rst clears the average and the fault, loads the register defaults
//   (real sensor, bandwidth 16, trip 65535, release 0) and drops m_tvalid.
// Stall:
//   a result waiting on m_tready does not block the next accept; the next
//   result is held in the sequencer until the waiting beat is taken.
// ----------------------------------------------------------------------------
module temp_average_overtemp_fault (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [taof_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [taof_pkg::SAMPLE_W-1:0]          cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [taof_pkg::IN_TDATA_W-1:0]        s_tdata,  // [15:0] adc_sample
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [taof_pkg::OUT_TDATA_W-1:0]       m_tdata   // [0] over_temp, [16:1] average_level
);

  taof_pkg::cmd_t                cmd;
  taof_pkg::status_t             status;
  logic                          over_temp;
  logic [taof_pkg::SAMPLE_W-1:0] average_level;

  // sequencer
  taof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  taof_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .adc_sample    (s_tdata[taof_pkg::SAMPLE_W-1:0]),
    .cmd           (cmd),
    .status        (status),
    .over_temp     (over_temp),
    .average_level (average_level)
  );

  // result beat packing, zero padded to whole bytes
  assign m_tdata = {{(taof_pkg::OUT_TDATA_W - taof_pkg::SAMPLE_W - 1){1'b0}},
                    average_level, over_temp};

endmodule

FILE: rtl/taof_dp.sv
// ----------------------------------------------------------------------------
// taof_dp
// Datapath: config registers, filter multiply, serial divider, fault check
// ----------------------------------------------------------------------------
module taof_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [taof_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [taof_pkg::SAMPLE_W-1:0]         cfg_data,
  input  logic [taof_pkg::SAMPLE_W-1:0]         adc_sample,
  input  taof_pkg::cmd_t                        cmd,
  output taof_pkg::status_t                     status,
  output logic                                  over_temp,
  output logic [taof_pkg::SAMPLE_W-1:0]         average_level
);

  logic                            sensor_mode;
  logic [taof_pkg::SAMPLE_W-1:0]   filter_bw;
  logic [taof_pkg::SAMPLE_W-1:0]   trip_level;
  logic [taof_pkg::SAMPLE_W-1:0]   release_level;

  logic [taof_pkg::SAMPLE_W-1:0]   sample;
  logic [taof_pkg::ACC_W-1:0]      prod;
  logic [taof_pkg::SAMPLE_W-1:0]   rem;
  logic [taof_pkg::SAMPLE_W-1:0]   quot;
  logic [taof_pkg::CNT_W-1:0]      cnt;
  logic                            use_quot;
  logic [taof_pkg::SAMPLE_W-1:0]   running_average;
  logic                            fault_flag;

  logic [taof_pkg::SAMPLE_W-1:0]   bw_eff;
  logic [taof_pkg::SAMPLE_W-1:0]   bw_m1;
  logic [taof_pkg::ACC_W-1:0]      acc;
  logic [taof_pkg::SAMPLE_W:0]     trial;
  logic [taof_pkg::SAMPLE_W:0]     trial_diff;
  logic                            trial_ge;
  logic [taof_pkg::SAMPLE_W-1:0]   average_next;
  logic                            fault_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_mode   <= taof_pkg::RST_SENSOR_MODE;
      filter_bw     <= taof_pkg::RST_FILTER_BW;
      trip_level    <= taof_pkg::RST_TRIP;
      release_level <= taof_pkg::RST_RELEASE;
    end else if (cfg_we) begin
      case (taof_pkg::reg_index_t'(cfg_index))
        taof_pkg::REG_SENSOR_MODE: sensor_mode   <= cfg_data[0];
        taof_pkg::REG_FILTER_BW:   filter_bw     <= cfg_data;
        taof_pkg::REG_TRIP:        trip_level    <= cfg_data;
        taof_pkg::REG_RELEASE:     release_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero bandwidth acts as one
  assign bw_eff = (filter_bw == '0) ? taof_pkg::SAMPLE_W'(1) : filter_bw;
  assign bw_m1  = bw_eff - taof_pkg::SAMPLE_W'(1);
  assign acc    = prod + {{taof_pkg::SAMPLE_W{1'b0}}, sample};

  // one restoring divide step: shift in the next dividend bit
  assign trial      = {rem, quot[taof_pkg::SAMPLE_W-1]};
  assign trial_diff = trial - {1'b0, bw_eff};
  assign trial_ge   = (trial >= {1'b0, bw_eff});

  // new average and hysteresis check
  always_comb begin
    average_next = use_quot ? quot : running_average;
    if (!sensor_mode) begin
      fault_next = 1'b0;
    end else if (average_next > trip_level) begin
      fault_next = 1'b1;
    end else if (average_next < release_level) begin
      fault_next = 1'b0;
    end else begin
      fault_next = fault_flag;
    end
  end

  // sample capture, multiply, divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= adc_sample;
    end
    if (cmd.mul) begin
      prod <= {{taof_pkg::SAMPLE_W{1'b0}}, bw_m1} *
              {{taof_pkg::SAMPLE_W{1'b0}}, running_average};
    end
    if (cmd.add) begin
      rem  <= acc[taof_pkg::ACC_W-1:taof_pkg::SAMPLE_W];
      quot <= acc[taof_pkg::SAMPLE_W-1:0];
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial_diff[taof_pkg::SAMPLE_W-1:0]
                       : trial[taof_pkg::SAMPLE_W-1:0];
      quot <= {quot[taof_pkg::SAMPLE_W-2:0], trial_ge};
    end
  end

  // step counter and quotient select
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      use_quot <= 1'b0;
    end else begin
      if (cmd.load) begin
        use_quot <= 1'b0;
      end else if (cmd.add) begin
        use_quot <= 1'b1;
      end
      if (cmd.add) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + taof_pkg::CNT_W'(1);
      end
    end
  end

  // filter state, also the result beat payload
  always_ff @(posedge clk) begin
    if (rst) begin
      running_average <= '0;
      fault_flag      <= 1'b0;
    end else if (cmd.commit) begin
      running_average <= average_next;
      fault_flag      <= fault_next;
    end
  end

  assign status.skip     = !sensor_mode || (sample == taof_pkg::FAILED_SAMPLE);
  assign status.div_last = (cnt == taof_pkg::CNT_W'(taof_pkg::DIV_STEPS - 1));
  assign over_temp       = fault_flag;
  assign average_level   = running_average;

endmodule

FILE: rtl/taof_ctrl.sv
// ----------------------------------------------------------------------------
// taof_ctrl
// Controller: sequences accept, multiply, add, divide and result beat
// ----------------------------------------------------------------------------
`include "temp_average_overtemp_fault_assert.svh"

module taof_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  taof_pkg::status_t status,
  output taof_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    MUL  = 5'b00010,
    ADD  = 5'b00100,
    DIV  = 5'b01000,
    FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = MUL;
        end
      end
      MUL: begin
        if (status.skip) begin
          state_next = FIN;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ADD;
        end
      end
      ADD: begin
        cmd.add    = 1'b1;
        state_next = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = FIN;
        end
      end
      FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // checks
  `TAOF_ASSERT_ALWAYS(a_one_cmd, clk, rst, $onehot0(cmd))
  `TAOF_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `TAOF_ASSERT_NEXT(a_commit_shows_beat, clk, rst, cmd.commit, m_tvalid && s_tready)

endmodule

FILE: test/temp_average_overtemp_fault_test.sv
// ----------------------------------------------------------------------------
// temp_average_overtemp_fault_test
// Self-checking bench for the temperature averaging filter and fault monitor
// ----------------------------------------------------------------------------
// Raw converter samples are sent as single beats. Each accepted beat is run
// through a local copy of the filter and the hysteresis check, and the
// expected fault flag and average are queued. Every result beat is compared
// field by field against the oldest queued value. Directed tests cover the
// register extremes, the failed conversion, zero bandwidth, crossed
// thresholds and virtual mode. Random phases then rewrite all registers and
// stream samples aimed across the thresholds, with random gaps on both sides but every fifth phase gapless.
// ----------------------------------------------------------------------------
module temp_average_overtemp_fault_test;
  import taof_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 22;
  localparam int PHASE_ITEMS   = 61;

  typedef struct packed {
    logic                over_temp;
    logic [SAMPLE_W-1:0] average_level;
  } reading_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  reg_index_t             cfg_index = REG_SENSOR_MODE;
  logic [SAMPLE_W-1:0]    cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [15:0] adc_sample
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [0] over_temp, [16:1] average_level

  // register mirror and filter state of the predictor
  logic                mode_q  = RST_SENSOR_MODE;
  logic [SAMPLE_W-1:0] bw_q    = RST_FILTER_BW;
  logic [SAMPLE_W-1:0] trip_q  = RST_TRIP;
  logic [SAMPLE_W-1:0] rel_q   = RST_RELEASE;
  logic [SAMPLE_W-1:0] avg_q   = '0;
  logic                fault_q = 1'b0;

  reading_t readings_q[$];
  int       items_sent   = 0;
  int       results_seen = 0;
  int       error_count  = 0;
  int       cycle_count  = 0;
  bit       gapless      = 1'b0;

  temp_average_overtemp_fault u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("temp_average_overtemp_fault_test: errors");
      $finish;
    end
  end

  // filter update and hysteresis check for one sample
  function automatic reading_t step_filter(input logic [SAMPLE_W-1:0] sample);
    logic [ACC_W-1:0] divisor;
    logic [ACC_W-1:0] acc;
    reading_t         r;
    if (mode_q) begin
      if (sample != FAILED_SAMPLE) begin
        divisor = (bw_q == '0) ? ACC_W'(1) : ACC_W'(bw_q);
        acc     = (divisor - ACC_W'(1)) * ACC_W'(avg_q) + ACC_W'(sample);
        avg_q   = SAMPLE_W'(acc / divisor);
      end
      // trip test first, so crossed thresholds favor the fault
      if (avg_q > trip_q)
        fault_q = 1'b1;
      else if (avg_q < rel_q)
        fault_q = 1'b0;
    end else begin
      fault_q = 1'b0;
    end
    r.over_temp     = fault_q;
    r.average_level = avg_q;
    return r;
  endfunction

  // one sample beat, with a random gap ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    readings_q.push_back(step_filter(sample));
    items_sent++;
  endtask

  // drop valid and hold off until every result beat has come back
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [SAMPLE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SENSOR_MODE: mode_q = val[0];
      REG_FILTER_BW:   bw_q   = val;
      REG_TRIP:        trip_q = val;
      REG_RELEASE:     rel_q  = val;
      default: ;
    endcase
  endtask

  // rewrite every register while the block is idle
  task automatic apply_setting(input logic mode, input logic [SAMPLE_W-1:0] bw,
                               input logic [SAMPLE_W-1:0] trip,
                               input logic [SAMPLE_W-1:0] rel);
    wait_results();
    put_reg(REG_SENSOR_MODE, {{(SAMPLE_W-1){1'b0}}, mode});
    put_reg(REG_FILTER_BW, bw);
    put_reg(REG_TRIP, trip);
    put_reg(REG_RELEASE, rel);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(16'd40000);
    send_sample(FAILED_SAMPLE);
    send_sample(16'hFFFE);
  endtask

  task automatic test_bandwidth_extremes();
    apply_setting(1'b1, 16'd1, 16'hFFFF, 16'd0);
    send_sample(16'hFFFE);
    send_sample(16'd0);
    // zero bandwidth behaves as one
    apply_setting(1'b1, 16'd0, 16'hFFFF, 16'd0);
    send_sample(16'd12345);
    send_sample(FAILED_SAMPLE);
    apply_setting(1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
    send_sample(16'hFFFE);
    send_sample(16'd0);
  endtask

  task automatic test_hysteresis();
    apply_setting(1'b1, 16'd1, 16'd1000, 16'd500);
    send_sample(16'd1500);
    send_sample(16'd800);
    send_sample(16'd400);
    send_sample(16'd800);
    send_sample(16'd1000);
    send_sample(16'd1001);
    send_sample(16'd500);
    send_sample(16'd499);
  endtask

  // failed conversion keeps the average but still re-checks the fault
  task automatic test_failed_conversion();
    apply_setting(1'b1, 16'd1, 16'd100, 16'd0);
    send_sample(FAILED_SAMPLE);
  endtask

  task automatic test_crossed_thresholds();
    apply_setting(1'b1, 16'd1, 16'd100, 16'd1000);
    send_sample(16'd500);
    send_sample(16'd50);
    send_sample(16'd101);
    apply_setting(1'b1, 16'd1, 16'd0, 16'hFFFF);
    send_sample(16'd0);
    send_sample(16'd1);
  endtask

  task automatic test_virtual_mode();
    apply_setting(1'b0, 16'd16, 16'd0, 16'd0);
    send_sample(16'd30000);
    send_sample(FAILED_SAMPLE);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_level(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return SAMPLE_W'(v);
  endfunction

  // random settings, samples steered across the thresholds
  task automatic test_random_phases();
    logic                mode;
    logic [SAMPLE_W-1:0] bw, trip, rel, sample;
    int                  base, span, off, pick;
    bit                  high_run;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 7))
        0:       bw = 16'd0;
        1:       bw = 16'd1;
        2:       bw = 16'hFFFF;
        3, 4:    bw = SAMPLE_W'($urandom_range(2, 16));
        5:       bw = SAMPLE_W'($urandom_range(17, 255));
        default: bw = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      base = $urandom_range(0, 65535);
      span = $urandom_range(0, 2000);
      rel  = clamp_level(base);
      trip = clamp_level(base + span);
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
        // crossed thresholds
        trip = clamp_level(base);
        rel  = clamp_level(base + span);
      end else if (pick == 2) begin
        trip = $urandom_range(0, 1) ? '1 : '0;
        rel  = $urandom_range(0, 1) ? '1 : '0;
      end
      apply_setting(mode, bw, trip, rel);
      gapless  = (p % 5 == 4);
      high_run = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 8 == 0) high_run = !high_run;
        off  = $urandom_range(0, 3000);
        pick = $urandom_range(0, 99);
        if (pick < 7)
          sample = FAILED_SAMPLE;
        else if (pick < 25)
          sample = SAMPLE_W'($urandom_range(0, 65535));
        else if (pick < 35)
          sample = $urandom_range(0, 1) ? 16'hFFFE : 16'd0;
        else if (high_run)
          sample = clamp_level(int'(trip) + off);
        else
          sample = clamp_level(int'(rel) - off);
        send_sample(sample);
        // occasional pause until everything has come back
        if ($urandom_range(0, 49) == 0) wait_results();
      end
      gapless = 1'b0;
    end
  endtask

  // result side stall
  initial begin : result_ready
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = gapless ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // compare each result beat with the oldest expected reading
  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (readings_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = readings_q.pop_front();
        if (m_tdata[0] !== want.over_temp) begin
          $display("%0t over_temp mismatch: expected %0d actual %0d",
                   $time, want.over_temp, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[SAMPLE_W:1] !== want.average_level) begin
          $display("%0t average_level mismatch: expected %0d actual %0d",
                   $time, want.average_level, m_tdata[SAMPLE_W:1]);
          error_count++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_bandwidth_extremes();
    test_hysteresis();
    test_failed_conversion();
    test_crossed_thresholds();
    test_virtual_mode();
    test_random_phases();
    wait_results();
    repeat (30) @(posedge clk);
    if (error_count == 0 && readings_q.size() == 0) begin
      $display("temp_average_overtemp_fault_test: clean");
    end else begin
      $display("temp_average_overtemp_fault_test: errors");
    end
    $finish;
  end

endmodule

FILE: temp_average_overtemp_fault.f
+incdir+rtl
rtl/taof_pkg.sv
rtl/taof_dp.sv
rtl/taof_ctrl.sv
rtl/temp_average_overtemp_fault.sv
test/temp_average_overtemp_fault_test.sv
